@@ rtl/ilid_pkg.sv @@
package ilid_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 6;   // count field width on the result channel

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_DUMP   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [POS_W-1:0]  raddr;
  } ram_req_t;

endpackage

@@ rtl/ilid_ram.sv @@
module ilid_ram
  import ilid_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  ram_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/indexed_list_insert_delete.sv @@
// Packed list of signed 32-bit words, capacity DEPTH, held in a single-port-write,
// registered-read RAM.
// Input channel (in_*): opcode on in_tuser, position and value on in_tdata.
// Result channel (out_*): status on out_tuser, entry and count on out_tdata,
// out_tlast marks the final result of an input item.
// Append, remove-tail and every rejected operation answer in the cycle after
// acceptance. Insert and delete move one word at a time through the shared
// index counter and RAM (read in S_SH_RD, written in S_SH_WR); S_FIN ends it.
// Dump reads one entry at a time and gives one result per entry. Unused
// opcodes are taken and give no result.
// One item is worked on at a time; in_tready is high only when the sequencer
// is idle and the result register is empty.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; RAM contents are not cleared, entries beyond the count are never read.
// When out_tready is low the result register holds and the sequencer waits
// (dump pauses between entries).
module indexed_list_insert_delete
  import ilid_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [5:0] position, [37:6] value, [39:38] zero
  input  logic [2:0]  in_tuser,   // [2:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] entry, [37:32] count, [39:38] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW + 1 : POS_W + 1;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SH_RD    = 6'b000010,
    S_SH_WR    = 6'b000100,
    S_FIN      = 6'b001000,
    S_DUMP_RD  = 6'b010000,
    S_DUMP_OUT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  op_t               op_r, op_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_entry_r, out_entry_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic              out_last_r, out_last_nxt;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  op_t               in_op;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_val;
  logic              in_fire;
  logic              out_free;
  logic              full;
  logic              empty;
  logic [CMPW-1:0]   pos_w, cnt_w, idx_w;
  logic [CW-1:0]     idx_inc, idx_dec;
  logic [POS_W-1:0]  pos_m1;

  assign in_op    = op_t'(in_tuser);
  assign in_pos   = in_tdata[POS_W-1:0];
  assign in_val   = in_tdata[POS_W+DATA_W-1:POS_W];
  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pos_w   = CMPW'(in_pos);
  assign cnt_w   = CMPW'(count_r);
  assign idx_w   = CMPW'(idx_r);
  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;
  assign pos_m1  = pos_r - 1'b1;

  ilid_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    ram_req        = '0;
    ram_req.wdata  = ram_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_op;
          pos_nxt        = in_pos;
          val_nxt        = in_val;
          out_status_nxt = ST_OK;
          out_entry_nxt  = '0;
          out_count_nxt  = CNT_W'(count_r);
          out_last_nxt   = 1'b1;
          case (in_op)
            OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = POS_W'(count_r);
                ram_req.wdata = in_val;
                count_nxt     = count_r + 1'b1;
                out_count_nxt = CNT_W'(count_r + 1'b1);
              end
            end
            OP_POP: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                count_nxt     = count_r - 1'b1;
                out_count_nxt = CNT_W'(count_r - 1'b1);
              end
            end
            OP_INSERT: begin
              if (full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end else if (in_pos == '0 || pos_w > cnt_w + 1'b1) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end else if (pos_w == cnt_w + 1'b1) begin
                state_nxt = S_FIN;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_SH_RD;
              end
            end
            OP_DELETE: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else if (in_pos == '0 || pos_w > cnt_w) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
              end else if (pos_w == cnt_w) begin
                state_nxt = S_FIN;
              end else begin
                idx_nxt   = CW'(in_pos);
                state_nxt = S_SH_RD;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DUMP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SH_RD: begin
        // insert moves slot idx-1 up to idx; delete moves idx down to idx-1
        ram_req.re    = 1'b1;
        ram_req.raddr = (op_r == OP_INSERT) ? POS_W'(idx_dec) : POS_W'(idx_r);
        state_nxt     = S_SH_WR;
      end
      S_SH_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = (op_r == OP_INSERT) ? POS_W'(idx_r) : POS_W'(idx_dec);
        if (op_r == OP_INSERT) begin
          if (idx_w == CMPW'(pos_r)) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_dec;
            state_nxt = S_SH_RD;
          end
        end else begin
          if (idx_inc == count_r) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_SH_RD;
          end
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        if (op_r == OP_INSERT) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_m1;
          ram_req.wdata = val_r;
          count_nxt     = count_r + 1'b1;
          out_count_nxt = CNT_W'(count_r + 1'b1);
        end else begin
          count_nxt     = count_r - 1'b1;
          out_count_nxt = CNT_W'(count_r - 1'b1);
        end
        state_nxt = S_IDLE;
      end
      S_DUMP_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = POS_W'(idx_r);
        state_nxt     = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        // read data register holds until the next read, so waiting is safe
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_entry_nxt  = ram_rdata;
          out_count_nxt  = CNT_W'(count_r);
          out_last_nxt   = (idx_inc == count_r);
          if (idx_inc == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_count_r, out_entry_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
